>>> rtl/bpa_pkg.sv
// Shared types and constants for the bitmap page allocator.
// Used by bpa_word_alu and bitmap_page_allocator; no dependencies.
`default_nettype none

package bpa_pkg;

  localparam int unsigned PAGE_COUNT     = 4096;
  localparam int unsigned PAGE_SHIFT     = 12;
  localparam int unsigned ADDR_W         = 24;
  localparam int unsigned CNT_W          = 13;
  localparam int unsigned SUM_W          = CNT_W + 1;
  localparam int unsigned CNT_MAX        = (1 << CNT_W) - 1;
  localparam int unsigned RESERVED_RESET = 256;
  localparam int unsigned RSV_ALIGN_W    = 3;

  localparam int unsigned PAGE_W      = $clog2(PAGE_COUNT);
  localparam int unsigned PIDX_W      = PAGE_W + 1;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned BIT_W       = $clog2(WORD_W);
  localparam int unsigned NUM_WORDS   = PAGE_COUNT / WORD_W;
  localparam int unsigned WORD_IDX_W  = $clog2(NUM_WORDS);
  localparam int unsigned ROW_W       = 2 * WORD_W;

  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned IN_USER_W   = FUNC_W + 1;
  localparam int unsigned OUT_DATA_W  = 40;

  typedef enum logic [FUNC_W-1:0] {
    FN_BEGIN_INIT  = 3'd0,
    FN_ADD_REGION  = 3'd1,
    FN_FINISH_INIT = 3'd2,
    FN_ALLOC       = 3'd3,
    FN_FREE        = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_RANGE   = 2'd2,
    ST_UNAVAIL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    WOP_ADD,
    WOP_RSV,
    WOP_ALLOC,
    WOP_FREE
  } wop_e;

  typedef struct packed {
    wop_e                  op;
    logic [WORD_IDX_W-1:0] word;
    logic [PIDX_W-1:0]     lo;
    logic [PIDX_W-1:0]     hi;
    logic [WORD_W-1:0]     used;
    logic [WORD_W-1:0]     avail;
  } walu_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] used;
    logic [WORD_W-1:0] avail;
    logic              hit;
    logic [BIT_W-1:0]  bit_idx;
  } walu_rsp_t;

endpackage

`default_nettype wire

>>> rtl/bitmap_page_allocator.sv
// Top level of the bitmap page allocator: command sequencer, word pipeline,
// row valid bits and result register. Uses bpa_pkg, bpa_map_ram, bpa_word_alu.
//
// channel   dir  handshake                 contents
// s_axis    in   s_axis_tvalid/tready      command beat (func, address, pages, usable)
// m_axis    out  m_axis_tvalid/tready      result beat (page address, usable count, status)
// cfg       in   cfg_we_i                  low page reserve count
//
// One bitmap word (64 pages of used and available bits) is read per cycle; a
// region, reserve or alloc walks words in order, free touches one word.
// A command is accepted in S_IDLE, walks its words in S_SCAN if it has any
// (memory read, word ALU, write-back), then loads the result beat in S_DONE.
// begin_init clears the 64 row valid bits at once; no clearing pass after reset.
// A new command is taken while a result beat still waits on m_axis_tready.
`default_nettype none

module bitmap_page_allocator (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [bpa_pkg::CNT_W-1:0]        cfg_wdata_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // address[23:0], page_count[36:24], zero pad[39:37]
  input  wire logic [bpa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // func[2:0], region_usable[3]
  input  wire logic [bpa_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // page_address[23:0], usable_pages[36:24], zero pad[39:37]
  output logic      [bpa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // status[1:0]
  output logic      [bpa_pkg::STATUS_W-1:0]     m_axis_tuser
);

  localparam int unsigned PW  = bpa_pkg::PIDX_W;
  localparam int unsigned WIW = bpa_pkg::WORD_IDX_W;
  localparam int unsigned PAD_W = bpa_pkg::OUT_DATA_W - bpa_pkg::CNT_W - bpa_pkg::ADDR_W;

  bpa_pkg::state_e                 state_q, state_d;
  bpa_pkg::wop_e                   op_q, op_d;
  logic [PW-1:0]                   lo_q, lo_d;
  logic [PW-1:0]                   hi_q, hi_d;
  logic [WIW-1:0]                  rd_w_q, rd_w_d;
  logic [WIW-1:0]                  last_w_q, last_w_d;
  logic [WIW-1:0]                  pw_q, pw_d;
  logic                            issue_done_q, issue_done_d;
  logic                            pend_q, pend_d;
  logic                            rvalid_q, rvalid_d;
  logic [bpa_pkg::NUM_WORDS-1:0]   row_valid_q, row_valid_d;
  logic [PW-1:0]                   ss_q, ss_d;
  logic [bpa_pkg::CNT_W-1:0]       rsv_q, rsv_d;
  logic [bpa_pkg::CNT_W-1:0]       count_q, count_d;
  logic [bpa_pkg::ADDR_W-1:0]      res_addr_q, res_addr_d;
  bpa_pkg::status_e                res_status_q, res_status_d;
  logic                            m_valid_q, m_valid_d;
  logic [bpa_pkg::ADDR_W-1:0]      m_addr_q, m_addr_d;
  bpa_pkg::status_e                m_status_q, m_status_d;
  logic [bpa_pkg::CNT_W-1:0]       m_count_q, m_count_d;

  logic                            s_fire;
  logic                            out_free;
  logic                            go_scan;
  logic                            scan_end;

  bpa_pkg::func_e                  in_func;
  logic                            in_usable;
  logic [bpa_pkg::ADDR_W-1:0]      in_addr;
  logic [bpa_pkg::CNT_W-1:0]       in_len;
  logic [bpa_pkg::PAGE_W-1:0]      in_page;
  logic [PW-1:0]                   room;
  logic [PW-1:0]                   n_pages;
  logic [PW-1:0]                   hi_new;
  logic [PW-1:0]                   hi_m1;
  logic [bpa_pkg::SUM_W-1:0]       cnt_sum;
  logic [bpa_pkg::CNT_W-1:0]       count_new;
  logic [bpa_pkg::CNT_W-1:0]       rsv_al;
  logic [PW-1:0]                   lim;
  logic [PW-1:0]                   lim_m1;
  logic [PW-1:0]                   cfg_clamp;

  logic                            ram_re;
  logic                            ram_we;
  logic [bpa_pkg::ROW_W-1:0]       ram_rdata;

  bpa_pkg::walu_req_t              walu_req;
  bpa_pkg::walu_rsp_t              walu_rsp;

  assign s_fire   = s_axis_tvalid & s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  // command field decode and range set-up
  always_comb begin
    in_func   = bpa_pkg::func_e'(s_axis_tuser[bpa_pkg::FUNC_W-1:0]);
    in_usable = s_axis_tuser[bpa_pkg::FUNC_W];
    in_addr   = s_axis_tdata[bpa_pkg::ADDR_W-1:0];
    in_len    = s_axis_tdata[bpa_pkg::ADDR_W +: bpa_pkg::CNT_W];
    in_page   = in_addr[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT];
    room      = PW'(bpa_pkg::PAGE_COUNT) - {1'b0, in_page};
    n_pages   = ({1'b0, in_len} < bpa_pkg::SUM_W'(room)) ? PW'(in_len) : room;
    hi_new    = {1'b0, in_page} + n_pages;
    hi_m1     = hi_new - PW'(1);
    cnt_sum   = bpa_pkg::SUM_W'(count_q) + bpa_pkg::SUM_W'(n_pages);
    count_new = (cnt_sum > bpa_pkg::SUM_W'(bpa_pkg::CNT_MAX)) ?
                bpa_pkg::CNT_W'(bpa_pkg::CNT_MAX) : cnt_sum[bpa_pkg::CNT_W-1:0];
    rsv_al    = {rsv_q[bpa_pkg::CNT_W-1:bpa_pkg::RSV_ALIGN_W], {bpa_pkg::RSV_ALIGN_W{1'b0}}};
    lim       = (bpa_pkg::SUM_W'(rsv_al) > bpa_pkg::SUM_W'(bpa_pkg::PAGE_COUNT)) ?
                PW'(bpa_pkg::PAGE_COUNT) : PW'(rsv_al);
    lim_m1    = lim - PW'(1);
    cfg_clamp = (bpa_pkg::SUM_W'(cfg_wdata_i) > bpa_pkg::SUM_W'(bpa_pkg::PAGE_COUNT)) ?
                PW'(bpa_pkg::PAGE_COUNT) : PW'(cfg_wdata_i);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpa_pkg::S_IDLE: begin
        if (s_fire) begin
          state_d = go_scan ? bpa_pkg::S_SCAN : bpa_pkg::S_DONE;
        end
      end
      bpa_pkg::S_SCAN: begin
        if (scan_end) begin
          state_d = bpa_pkg::S_DONE;
        end
      end
      bpa_pkg::S_DONE: begin
        if (out_free) begin
          state_d = bpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bpa_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_d         = op_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    rd_w_d       = rd_w_q;
    last_w_d     = last_w_q;
    pw_d         = pw_q;
    issue_done_d = issue_done_q;
    pend_d       = 1'b0;
    rvalid_d     = rvalid_q;
    row_valid_d  = row_valid_q;
    ss_d         = ss_q;
    rsv_d        = rsv_q;
    count_d      = count_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    m_valid_d    = m_valid_q & ~m_axis_tready;
    m_addr_d     = m_addr_q;
    m_status_d   = m_status_q;
    m_count_d    = m_count_q;
    go_scan      = 1'b0;
    scan_end     = 1'b0;
    ram_re       = 1'b0;
    ram_we       = 1'b0;

    if (cfg_we_i) begin
      rsv_d = cfg_wdata_i;
      ss_d  = cfg_clamp;
    end

    unique case (state_q)
      bpa_pkg::S_IDLE: begin
        if (s_fire) begin
          res_addr_d   = '0;
          res_status_d = bpa_pkg::ST_OK;
          issue_done_d = 1'b0;
          unique case (in_func)
            bpa_pkg::FN_BEGIN_INIT: begin
              row_valid_d = '0;
              count_d     = '0;
            end
            bpa_pkg::FN_ADD_REGION: begin
              if (in_usable && n_pages != '0) begin
                go_scan  = 1'b1;
                op_d     = bpa_pkg::WOP_ADD;
                lo_d     = {1'b0, in_page};
                hi_d     = hi_new;
                rd_w_d   = in_page[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W];
                last_w_d = hi_m1[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W];
                count_d  = count_new;
              end
            end
            bpa_pkg::FN_FINISH_INIT: begin
              if (lim != '0) begin
                go_scan  = 1'b1;
                op_d     = bpa_pkg::WOP_RSV;
                lo_d     = '0;
                hi_d     = lim;
                rd_w_d   = '0;
                last_w_d = lim_m1[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W];
              end
            end
            bpa_pkg::FN_ALLOC: begin
              if (ss_q[bpa_pkg::PAGE_W]) begin
                res_status_d = bpa_pkg::ST_OOM;
              end else begin
                go_scan  = 1'b1;
                op_d     = bpa_pkg::WOP_ALLOC;
                lo_d     = ss_q;
                hi_d     = PW'(bpa_pkg::PAGE_COUNT);
                rd_w_d   = ss_q[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W];
                last_w_d = WIW'(bpa_pkg::NUM_WORDS - 1);
              end
            end
            bpa_pkg::FN_FREE: begin
              if ({1'b0, in_page} >= PW'(bpa_pkg::PAGE_COUNT)) begin
                res_status_d = bpa_pkg::ST_RANGE;
              end else begin
                go_scan  = 1'b1;
                op_d     = bpa_pkg::WOP_FREE;
                lo_d     = {1'b0, in_page};
                hi_d     = {1'b0, in_page};
                rd_w_d   = in_page[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W];
                last_w_d = in_page[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W];
              end
            end
            default: begin
            end
          endcase
        end
      end

      bpa_pkg::S_SCAN: begin
        // write back the word that came out of the memory this cycle
        if (pend_q) begin
          ram_we            = 1'b1;
          row_valid_d[pw_q] = 1'b1;
          if (op_q == bpa_pkg::WOP_ALLOC && walu_rsp.hit) begin
            scan_end   = 1'b1;
            res_addr_d = bpa_pkg::ADDR_W'({pw_q, walu_rsp.bit_idx}) << bpa_pkg::PAGE_SHIFT;
            ss_d       = {1'b0, pw_q, walu_rsp.bit_idx} + PW'(1);
          end else if (pw_q == last_w_q) begin
            scan_end = 1'b1;
            if (op_q == bpa_pkg::WOP_ALLOC) begin
              res_status_d = bpa_pkg::ST_OOM;
            end
            if (op_q == bpa_pkg::WOP_FREE) begin
              if (!walu_rsp.hit) begin
                res_status_d = bpa_pkg::ST_UNAVAIL;
              end else if (lo_q < ss_q) begin
                ss_d = lo_q;
              end
            end
          end
        end
        // read ahead the next word
        if (!scan_end && !issue_done_q) begin
          ram_re   = 1'b1;
          pend_d   = 1'b1;
          pw_d     = rd_w_q;
          rvalid_d = row_valid_q[rd_w_q];
          if (rd_w_q == last_w_q) begin
            issue_done_d = 1'b1;
          end else begin
            rd_w_d = rd_w_q + WIW'(1);
          end
        end
      end

      bpa_pkg::S_DONE: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_addr_d   = res_addr_q;
          m_status_d = res_status_q;
          m_count_d  = count_q;
        end
      end

      default: begin
      end
    endcase
  end

  // rows never written since begin_init read as all used, none available
  always_comb begin
    walu_req.op    = op_q;
    walu_req.word  = pw_q;
    walu_req.lo    = lo_q;
    walu_req.hi    = hi_q;
    walu_req.used  = rvalid_q ? ram_rdata[bpa_pkg::WORD_W-1:0] : {bpa_pkg::WORD_W{1'b1}};
    walu_req.avail = rvalid_q ? ram_rdata[bpa_pkg::ROW_W-1:bpa_pkg::WORD_W] : '0;
  end

  bpa_word_alu u_word_alu (
    .req_i (walu_req),
    .rsp_o (walu_rsp)
  );

  bpa_map_ram #(
    .WIDTH (bpa_pkg::ROW_W),
    .DEPTH (bpa_pkg::NUM_WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pw_q),
    .wdata_i ({walu_rsp.avail, walu_rsp.used}),
    .re_i    (ram_re),
    .raddr_i (rd_w_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bpa_pkg::S_IDLE;
      issue_done_q <= 1'b0;
      pend_q       <= 1'b0;
      row_valid_q  <= '0;
      ss_q         <= PW'(bpa_pkg::RESERVED_RESET);
      rsv_q        <= bpa_pkg::CNT_W'(bpa_pkg::RESERVED_RESET);
      count_q      <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      issue_done_q <= issue_done_d;
      pend_q       <= pend_d;
      row_valid_q  <= row_valid_d;
      ss_q         <= ss_d;
      rsv_q        <= rsv_d;
      count_q      <= count_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    rd_w_q       <= rd_w_d;
    last_w_q     <= last_w_d;
    pw_q         <= pw_d;
    rvalid_q     <= rvalid_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    m_addr_q     <= m_addr_d;
    m_status_q   <= m_status_d;
    m_count_q    <= m_count_d;
  end

  assign s_axis_tready = (state_q == bpa_pkg::S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, m_count_q, m_addr_q};
  assign m_axis_tuser  = m_status_q;

endmodule

`default_nettype wire

>>> rtl/bpa_map_ram.sv
// Simple dual-port bitmap memory, one write and one registered read port.
// Generic; no package dependencies.
`default_nettype none

module bpa_map_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/bpa_word_alu.sv
// Per-word modify and search logic for one 64-page bitmap word.
// Depends on bpa_pkg for the request and response structs.
`default_nettype none

module bpa_word_alu (
  input  wire bpa_pkg::walu_req_t req_i,
  output bpa_pkg::walu_rsp_t      rsp_o
);

  localparam int unsigned W = bpa_pkg::WORD_W;

  logic [W-1:0]              lo_mask;
  logic [W-1:0]              hi_mask;
  logic [W-1:0]              range_mask;
  logic [W-1:0]              cand;
  logic [W-1:0]              first_one;
  logic [W-1:0]              bit_sel;
  logic [bpa_pkg::BIT_W-1:0] enc;

  always_comb begin
    lo_mask = {W{1'b1}};
    if (!req_i.lo[bpa_pkg::PAGE_W] &&
        req_i.word == req_i.lo[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W]) begin
      lo_mask = {W{1'b1}} << req_i.lo[bpa_pkg::BIT_W-1:0];
    end
    hi_mask = {W{1'b1}};
    if (!req_i.hi[bpa_pkg::PAGE_W] &&
        req_i.word == req_i.hi[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W]) begin
      hi_mask = (W'(1) << req_i.hi[bpa_pkg::BIT_W-1:0]) - W'(1);
    end
    range_mask = lo_mask & hi_mask;
  end

  // lowest free page at or above the search start
  always_comb begin
    cand      = ~req_i.used & lo_mask;
    first_one = cand & (~cand + W'(1));
    enc       = '0;
    for (int i = 0; i < W; i++) begin
      if (first_one[i]) begin
        enc = enc | bpa_pkg::BIT_W'(i);
      end
    end
    bit_sel = W'(1) << req_i.lo[bpa_pkg::BIT_W-1:0];
  end

  always_comb begin
    rsp_o.used    = req_i.used;
    rsp_o.avail   = req_i.avail;
    rsp_o.hit     = 1'b0;
    rsp_o.bit_idx = enc;
    case (req_i.op)
      bpa_pkg::WOP_ADD: begin
        rsp_o.used  = req_i.used & ~range_mask;
        rsp_o.avail = req_i.avail | range_mask;
      end
      bpa_pkg::WOP_RSV: begin
        rsp_o.used  = req_i.used | range_mask;
        rsp_o.avail = req_i.avail & ~range_mask;
      end
      bpa_pkg::WOP_ALLOC: begin
        rsp_o.used = req_i.used | first_one;
        rsp_o.hit  = |cand;
      end
      bpa_pkg::WOP_FREE: begin
        rsp_o.hit     = |(req_i.avail & bit_sel);
        rsp_o.bit_idx = req_i.lo[bpa_pkg::BIT_W-1:0];
        if (rsp_o.hit) begin
          rsp_o.used = req_i.used & ~bit_sel;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
